@@ design/rle_pkg.sv @@
// Shared types and constants for the run-length map decoder.
// Used by rle_alu, rle_emitter and rle_map_decoder_unit; depends on nothing.

package rle_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 7;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned LEN_W    = POS_W + 1;
    localparam int unsigned ALU_W    = LEN_W + 1;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned VCOUNT_W = 3;
    localparam int unsigned CHUNK    = 4;

    localparam logic [INDEX_W-1:0] MAP_SELECT_RESET = 8'd0;
    localparam logic [POS_W-1:0]   MAP_LENGTH_RESET = 16'd12288;

    // Configuration register indexes.
    localparam logic CFG_MAP_SELECT = 1'b0;
    localparam logic CFG_MAP_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CMP,
        ST_CLIP,
        ST_LOAD
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Run handed from the sequencer to the chunk emitter.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] value;
        logic               done;
        logic               clipped;
    } emit_cmd_t;

endpackage

@@ design/rle_alu.sv @@
// Shared add/subtract unit of the run-length map decoder.
// Depends on rle_pkg for widths and the operation type.

module rle_alu
(
    input  rle_pkg::alu_op_t              op,
    input  logic [rle_pkg::LEN_W-1:0]     a,
    input  logic [rle_pkg::LEN_W-1:0]     b,
    output logic [rle_pkg::ALU_W-1:0]     result
);

    logic [rle_pkg::ALU_W-1:0] a_ext;
    logic [rle_pkg::ALU_W-1:0] b_ext;
    logic [rle_pkg::ALU_W-1:0] b_mod;
    logic [rle_pkg::ALU_W-1:0] carry_in;

    assign a_ext = {1'b0, a};
    assign b_ext = {1'b0, b};

    always_comb
    begin
        unique case (op)
            rle_pkg::ALU_ADD:
            begin
                b_mod    = b_ext;
                carry_in = '0;
            end
            rle_pkg::ALU_SUB:
            begin
                b_mod    = ~b_ext;
                carry_in = {{(rle_pkg::ALU_W-1){1'b0}}, 1'b1};
            end
            default:
            begin
                b_mod    = b_ext;
                carry_in = '0;
            end
        endcase
    end

    // For a subtraction the top bit is set exactly when a is below b.
    assign result = a_ext + b_mod + carry_in;

endmodule

@@ design/rle_emitter.sv @@
// Chunk emitter and output register of the run-length map decoder.
// Splits a run into beats of up to four bytes. Depends on rle_pkg.

module rle_emitter
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  rle_pkg::emit_cmd_t               cmd,
    output logic                             busy,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rle_pkg::VALUE_W-1:0]      out_byte_a,
    output logic [rle_pkg::VALUE_W-1:0]      out_byte_b,
    output logic [rle_pkg::VALUE_W-1:0]      out_byte_c,
    output logic [rle_pkg::VALUE_W-1:0]      out_byte_d,
    output logic [rle_pkg::VCOUNT_W-1:0]     valid_count,
    output logic                             chunk_last,
    output logic                             map_done,
    output logic                             overrun
);

    localparam logic [rle_pkg::COUNT_W-1:0] CHUNK_CNT = rle_pkg::COUNT_W'(rle_pkg::CHUNK);

    logic [rle_pkg::COUNT_W-1:0]  left_reg;
    logic [rle_pkg::VALUE_W-1:0]  value_reg;
    logic                         done_reg;
    logic                         clipped_reg;

    logic                         out_valid_reg;
    logic [rle_pkg::VALUE_W-1:0]  byte_reg [rle_pkg::CHUNK];
    logic [rle_pkg::VCOUNT_W-1:0] count_reg;
    logic                         last_reg;
    logic                         done_out_reg;
    logic                         overrun_reg;

    logic                         advance;
    logic                         is_last;
    logic [rle_pkg::COUNT_W-1:0]  take;

    assign busy    = (left_reg != '0);
    assign advance = busy && (!out_valid_reg || !out_stall);
    assign is_last = (left_reg <= CHUNK_CNT);
    assign take    = is_last ? left_reg : CHUNK_CNT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                left_reg <= cmd.count;
            else if (advance)
                left_reg <= left_reg - take;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg   <= cmd.value;
            done_reg    <= cmd.done;
            clipped_reg <= cmd.clipped;
        end
        if (advance)
        begin
            for (int k = 0; k < rle_pkg::CHUNK; k++)
            begin
                byte_reg[k] <= (rle_pkg::COUNT_W'(k) < take) ? value_reg : '0;
            end
            count_reg    <= take[rle_pkg::VCOUNT_W-1:0];
            last_reg     <= is_last;
            done_out_reg <= is_last && done_reg;
            overrun_reg  <= is_last && clipped_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte_a  = byte_reg[0];
    assign out_byte_b  = byte_reg[1];
    assign out_byte_c  = byte_reg[2];
    assign out_byte_d  = byte_reg[3];
    assign valid_count = count_reg;
    assign chunk_last  = last_reg;
    assign map_done    = done_out_reg;
    assign overrun     = overrun_reg;

endmodule

@@ design/rle_map_decoder_unit.sv @@
// Top level of the run-length map decoder: sequencer, decoder state and config.
// Depends on rle_pkg, rle_alu and rle_emitter.
//
// Usage: code bytes arrive on the input channel (in_valid, in_stall, code_byte,
// stream_start); stream_start on a beat clears all decoder state before the
// byte is used. Decoded bytes of the selected map leave on the output channel
// (out_valid, out_stall) in beats of up to four bytes; valid_count tells how
// many are used and chunk_last marks the final beat caused by one input byte,
// which also carries map_done and overrun. Registers map_select and map_length are
// written over cfg_valid/cfg_ready with cfg_index/cfg_data; the user must do so only
// while the block is idle, as the block does not enforce it. cfg_ready is always high.
// Steps: a run marker or an ignored byte uses idle alone, a byte of a skipped map
// add and compare, a literal or run count of the selected map add, compare and
// load, with clip before load when the run is clipped and clip then idle when
// nothing of the map is left; the sequencer walks one shared 18-bit adder.
// Beats follow at one per cycle while the receiver does not stall, ceil(n/4)
// beats for n bytes. The next byte is taken while the last beat of a run waits.
// A stalled receiver holds the output register; once the emitter is full the
// sequencer waits in its load step and in_stall stays high.
// Reset clears sequencer state and flags, map_select to 0 and map_length to 12288.

module rle_map_decoder_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rle_pkg::BYTE_W-1:0]       code_byte,
    input  logic                             stream_start,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rle_pkg::VALUE_W-1:0]      out_byte_a,
    output logic [rle_pkg::VALUE_W-1:0]      out_byte_b,
    output logic [rle_pkg::VALUE_W-1:0]      out_byte_c,
    output logic [rle_pkg::VALUE_W-1:0]      out_byte_d,
    output logic [rle_pkg::VCOUNT_W-1:0]     valid_count,
    output logic                             chunk_last,
    output logic                             map_done,
    output logic                             overrun,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [rle_pkg::POS_W-1:0]        cfg_data
);

    rle_pkg::state_t               state_reg, state_next;
    logic [rle_pkg::INDEX_W-1:0]   map_select_reg;
    logic [rle_pkg::POS_W-1:0]     map_length_reg;
    logic [rle_pkg::POS_W-1:0]     position_reg, position_next;
    logic [rle_pkg::INDEX_W-1:0]   map_index_reg, map_index_next;
    logic                          pending_reg, pending_next;
    logic [rle_pkg::VALUE_W-1:0]   run_value_reg, run_value_next;
    logic                          finished_reg, finished_next;
    logic [rle_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [rle_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [rle_pkg::LEN_W-1:0]     sum_reg, sum_next;
    rle_pkg::emit_cmd_t            cmd_reg, cmd_next;

    rle_pkg::alu_op_t              alu_op;
    logic [rle_pkg::LEN_W-1:0]     alu_a;
    logic [rle_pkg::LEN_W-1:0]     alu_b;
    logic [rle_pkg::ALU_W-1:0]     alu_result;

    logic [rle_pkg::LEN_W-1:0]     len;
    logic                          in_accept;
    logic                          emit_busy;
    logic                          emit_load;
    logic                          diff_ge;
    logic                          diff_gt;
    logic                          fin_eff;
    logic                          pend_eff;

    // A zero length register stands for a full 65536-byte map.
    assign len = (map_length_reg == '0) ? {1'b1, {rle_pkg::POS_W{1'b0}}}
                                        : {1'b0, map_length_reg};

    assign in_stall  = (state_reg != rle_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign diff_ge = !alu_result[rle_pkg::ALU_W-1];
    assign diff_gt = diff_ge && (alu_result[rle_pkg::LEN_W-1:0] != '0);

    assign fin_eff  = stream_start ? 1'b0 : finished_reg;
    assign pend_eff = stream_start ? 1'b0 : pending_reg;

    rle_alu u_alu
    (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result)
    );

    rle_emitter u_emitter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (emit_load),
        .cmd         (cmd_reg),
        .busy        (emit_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte_a  (out_byte_a),
        .out_byte_b  (out_byte_b),
        .out_byte_c  (out_byte_c),
        .out_byte_d  (out_byte_d),
        .valid_count (valid_count),
        .chunk_last  (chunk_last),
        .map_done    (map_done),
        .overrun     (overrun)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rle_pkg::ST_IDLE;
            map_select_reg <= rle_pkg::MAP_SELECT_RESET;
            map_length_reg <= rle_pkg::MAP_LENGTH_RESET;
            position_reg   <= '0;
            map_index_reg  <= '0;
            pending_reg    <= 1'b0;
            run_value_reg  <= '0;
            finished_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            map_index_reg <= map_index_next;
            pending_reg   <= pending_next;
            run_value_reg <= run_value_next;
            finished_reg  <= finished_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    rle_pkg::CFG_MAP_SELECT:
                        map_select_reg <= cfg_data[rle_pkg::INDEX_W-1:0];
                    rle_pkg::CFG_MAP_LENGTH:
                        map_length_reg <= cfg_data;
                    default:
                        map_length_reg <= map_length_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        value_reg <= value_next;
        sum_reg   <= sum_next;
        cmd_reg   <= cmd_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        position_next  = position_reg;
        map_index_next = map_index_reg;
        pending_next   = pending_reg;
        run_value_next = run_value_reg;
        finished_next  = finished_reg;
        count_next     = count_reg;
        value_next     = value_reg;
        sum_next       = sum_reg;
        cmd_next       = cmd_reg;
        emit_load      = 1'b0;
        alu_op         = rle_pkg::ALU_ADD;
        alu_a          = {1'b0, position_reg};
        alu_b          = {{(rle_pkg::LEN_W-rle_pkg::COUNT_W){1'b0}}, count_reg};

        unique case (state_reg)
            rle_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (stream_start)
                    begin
                        position_next  = '0;
                        map_index_next = '0;
                        pending_next   = 1'b0;
                        run_value_next = '0;
                        finished_next  = 1'b0;
                    end
                    if (!fin_eff)
                    begin
                        if (pend_eff)
                        begin
                            pending_next = 1'b0;
                            count_next   = {1'b0, code_byte} + 1'b1;
                            value_next   = stream_start ? '0 : run_value_reg;
                            state_next   = rle_pkg::ST_ADD;
                        end
                        else if (code_byte[rle_pkg::BYTE_W-1])
                        begin
                            run_value_next = code_byte[rle_pkg::VALUE_W-1:0];
                            pending_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = {{(rle_pkg::COUNT_W-1){1'b0}}, 1'b1};
                            value_next = code_byte[rle_pkg::VALUE_W-1:0];
                            state_next = rle_pkg::ST_ADD;
                        end
                    end
                end
            end

            rle_pkg::ST_ADD:
            begin
                sum_next   = alu_result[rle_pkg::LEN_W-1:0];
                state_next = rle_pkg::ST_CMP;
            end

            rle_pkg::ST_CMP:
            begin
                alu_op = rle_pkg::ALU_SUB;
                alu_a  = sum_reg;
                alu_b  = len;
                if (map_index_reg != map_select_reg)
                begin
                    // Skipped map: a run past the end is dropped and the next map starts.
                    if (diff_ge)
                    begin
                        position_next  = '0;
                        map_index_next = map_index_reg + 1'b1;
                    end
                    else
                    begin
                        position_next = sum_reg[rle_pkg::POS_W-1:0];
                    end
                    state_next = rle_pkg::ST_IDLE;
                end
                else if (!diff_gt)
                begin
                    position_next    = sum_reg[rle_pkg::POS_W-1:0];
                    finished_next    = diff_ge;
                    cmd_next.count   = count_reg;
                    cmd_next.value   = value_reg;
                    cmd_next.done    = diff_ge;
                    cmd_next.clipped = 1'b0;
                    state_next       = rle_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = rle_pkg::ST_CLIP;
                end
            end

            rle_pkg::ST_CLIP:
            begin
                alu_op        = rle_pkg::ALU_SUB;
                alu_a         = len;
                alu_b         = {1'b0, position_reg};
                finished_next = 1'b1;
                if (diff_gt)
                begin
                    // The run is cut to what is left of the map.
                    position_next    = len[rle_pkg::POS_W-1:0];
                    cmd_next.count   = alu_result[rle_pkg::COUNT_W-1:0];
                    cmd_next.value   = value_reg;
                    cmd_next.done    = 1'b1;
                    cmd_next.clipped = 1'b1;
                    state_next       = rle_pkg::ST_LOAD;
                end
                else
                begin
                    // Nothing left of the map: it finishes with no beats.
                    state_next = rle_pkg::ST_IDLE;
                end
            end

            rle_pkg::ST_LOAD:
            begin
                if (!emit_busy)
                begin
                    emit_load  = 1'b1;
                    state_next = rle_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
